### sv/pidc_pkg.sv
// PID controller package: shared constants, register map, config and
// controller/datapath command and status types. No dependencies.
package pidc_pkg;

    localparam int DEF_SAMPLE_BITS = 16;
    localparam int DEF_FRAC_BITS   = 8;

    localparam int GAIN_W  = 16;
    localparam int TIME_W  = 32;
    localparam int DRIVE_W = 32;
    localparam int INTEG_W = 32;
    localparam int LIMIT_W = 31;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 5;
    localparam int IDX_W   = PADDR_W - 2;

    localparam logic [DRIVE_W-1:0] FLOOR_RST   = 32'hFFFF_8000;
    localparam logic [DRIVE_W-1:0] CEILING_RST = 32'h0000_7FFF;
    localparam logic [LIMIT_W-1:0] LIMIT_RST   = 31'h7FFF_FFFF;

    typedef enum logic [IDX_W-1:0] {
        REG_PROP_GAIN      = 3'd0,
        REG_INTEG_GAIN     = 3'd1,
        REG_DERIV_GAIN     = 3'd2,
        REG_OUTPUT_FLOOR   = 3'd3,
        REG_OUTPUT_CEILING = 3'd4,
        REG_INTEG_LIMIT    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [DRIVE_W-1:0] output_floor;
        logic [DRIVE_W-1:0] output_ceiling;
        logic [LIMIT_W-1:0] integ_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_EDT,
        OP_INTEG,
        OP_DIV_START,
        OP_MUL_P,
        OP_ADD_P,
        OP_MUL_D,
        OP_ADD_D,
        OP_MUL_I,
        OP_ADD_I,
        OP_OUT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic use_dt;
        logic div_done;
    } dp_sts_t;

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

### sv/pid_controller_step.sv
// Input transfers are accepted only in the idle state, so the block finishes one
// sample before it takes the next. The divider retires one quotient bit per
// cycle and is skipped on the first sample or when dt is zero.
// A new sample is taken while the previous result still waits on the output.
// Reset: asynchronous active-low; clears history and integral, loads register defaults.
module pid_controller_step #(
    parameter int SAMPLE_BITS = pidc_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = pidc_pkg::DEF_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pidc_pkg::PADDR_W-1:0]        paddr,
    input  logic [pidc_pkg::DATA_W-1:0]         pwdata,
    output logic [pidc_pkg::DATA_W-1:0]         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       measured,
    input  logic signed [SAMPLE_BITS-1:0]       setpoint,
    input  logic [pidc_pkg::TIME_W-1:0]         time_ms,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [pidc_pkg::DRIVE_W-1:0] drive
);
    import pidc_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;
    dp_sts_t sts;

    pidc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    pidc_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .cfg      (cfg),
        .measured (measured),
        .setpoint (setpoint),
        .time_ms  (time_ms),
        .drive    (drive)
    );

endmodule

### sv/pidc_cfg.sv
// PID controller configuration registers behind an APB-style port.
// Depends on pidc_pkg.
module pidc_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pidc_pkg::PADDR_W-1:0] paddr,
    input  logic [pidc_pkg::DATA_W-1:0]  pwdata,
    output logic [pidc_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output pidc_pkg::cfg_t               cfg
);
    import pidc_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PROP_GAIN:      cfg_next.prop_gain      = pwdata[GAIN_W-1:0];
                REG_INTEG_GAIN:     cfg_next.integ_gain     = pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN:     cfg_next.deriv_gain     = pwdata[GAIN_W-1:0];
                REG_OUTPUT_FLOOR:   cfg_next.output_floor   = pwdata[DRIVE_W-1:0];
                REG_OUTPUT_CEILING: cfg_next.output_ceiling = pwdata[DRIVE_W-1:0];
                REG_INTEG_LIMIT:    cfg_next.integ_limit    = pwdata[LIMIT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PROP_GAIN:      prdata = DATA_W'($signed(cfg_reg.prop_gain));
            REG_INTEG_GAIN:     prdata = DATA_W'($signed(cfg_reg.integ_gain));
            REG_DERIV_GAIN:     prdata = DATA_W'($signed(cfg_reg.deriv_gain));
            REG_OUTPUT_FLOOR:   prdata = cfg_reg.output_floor;
            REG_OUTPUT_CEILING: prdata = cfg_reg.output_ceiling;
            REG_INTEG_LIMIT:    prdata = DATA_W'(cfg_reg.integ_limit);
            default:            prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= '0;
            cfg_reg.integ_gain     <= '0;
            cfg_reg.deriv_gain     <= '0;
            cfg_reg.output_floor   <= FLOOR_RST;
            cfg_reg.output_ceiling <= CEILING_RST;
            cfg_reg.integ_limit    <= LIMIT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### sv/pidc_div.sv
// PID controller derivative divider: signed numerator by unsigned time
// step, one quotient bit per cycle, truncated toward zero. Depends on pidc_pkg.
module pidc_div #(
    parameter int NUM_W = pidc_pkg::DEF_SAMPLE_BITS + pidc_pkg::DEF_FRAC_BITS + 2
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [NUM_W-1:0]     num,
    input  logic [pidc_pkg::TIME_W-1:0] den,
    output logic                        done,
    output logic signed [NUM_W-1:0]     quo
);
    import pidc_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              neg_reg;
    logic [NUM_W-1:0]  mag_reg;
    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] den_reg;
    logic [TIME_W:0]   rem_sh;
    logic [TIME_W:0]   rem_diff;
    logic              ge;

    assign rem_sh   = {rem_reg, mag_reg[NUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, den_reg};
    assign ge       = rem_sh >= {1'b0, den_reg};
    assign done     = done_reg;
    assign quo      = neg_reg ? (~mag_reg + 1'b1) : mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(NUM_W);
        end
        else
        begin
            done_reg <= busy_reg && (cnt_reg == CNT_W'(1));
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num[NUM_W-1] ? (~num + 1'b1) : num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_diff[TIME_W-1:0] : rem_sh[TIME_W-1:0];
            mag_reg <= {mag_reg[NUM_W-2:0], ge};
        end
    end

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done longer than one cycle");

endmodule

### sv/pidc_dpath.sv
// PID controller datapath: sample state, shared multiplier, integral clamp,
// output accumulator and saturation. Depends on pidc_pkg and pidc_div.
module pidc_dpath #(
    parameter int SAMPLE_BITS = pidc_pkg::DEF_SAMPLE_BITS,
    parameter int FRAC_BITS   = pidc_pkg::DEF_FRAC_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pidc_pkg::dp_cmd_t                   cmd,
    output pidc_pkg::dp_sts_t                   sts,
    input  pidc_pkg::cfg_t                      cfg,
    input  logic signed [SAMPLE_BITS-1:0]       measured,
    input  logic signed [SAMPLE_BITS-1:0]       setpoint,
    input  logic [pidc_pkg::TIME_W-1:0]         time_ms,
    output logic signed [pidc_pkg::DRIVE_W-1:0] drive
);
    import pidc_pkg::*;

    localparam int ERR_W     = SAMPLE_BITS + 1;
    localparam int DIFF_W    = SAMPLE_BITS + 2;
    localparam int NUM_W     = DIFF_W + FRAC_BITS;
    localparam int MA_W      = max_int(TIME_W + 1, max_int(NUM_W, INTEG_W));
    localparam int MB_W      = max_int(ERR_W, GAIN_W);
    localparam int PROD_W    = MA_W + MB_W;
    localparam int INT_SUM_W = PROD_W + 1;
    localparam int ACC_W     = PROD_W + FRAC_BITS + 2;

    logic                        first_reg;
    logic signed [ERR_W-1:0]     last_err_reg;
    logic [TIME_W-1:0]           last_time_reg;
    logic signed [INTEG_W-1:0]   integ_reg;
    logic                        use_dt_reg;

    logic signed [ERR_W-1:0]     err_reg;
    logic [TIME_W-1:0]           dt_reg;
    logic signed [NUM_W-1:0]     num_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [DRIVE_W-1:0]   drive_reg;

    logic signed [ERR_W-1:0]     err_in;
    logic signed [DIFF_W-1:0]    diff_in;
    logic [TIME_W-1:0]           dt_in;
    logic signed [MA_W-1:0]      mul_a;
    logic signed [MB_W-1:0]      mul_b;
    logic signed [NUM_W-1:0]     div_quo;
    logic signed [NUM_W-1:0]     deriv;
    logic                        div_done;
    logic signed [INT_SUM_W-1:0] int_add;
    logic signed [INT_SUM_W-1:0] int_sum;
    logic signed [INT_SUM_W-1:0] lim_pos;
    logic signed [INT_SUM_W-1:0] lim_neg;
    logic signed [INT_SUM_W-1:0] int_clamped;
    logic signed [ACC_W-1:0]     shifted;
    logic signed [ACC_W-1:0]     floor_x;
    logic signed [ACC_W-1:0]     ceil_x;
    logic signed [ACC_W-1:0]     sat_val;
    logic signed [INTEG_W-1:0]   lim32;

    assign err_in  = ERR_W'(measured) - ERR_W'(setpoint);
    assign diff_in = DIFF_W'(err_in) - DIFF_W'(last_err_reg);
    assign dt_in   = time_ms - last_time_reg;

    pidc_div #(
        .NUM_W (NUM_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_DIV_START),
        .num   (num_reg),
        .den   (dt_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    assign deriv        = use_dt_reg ? div_quo : '0;
    assign sts.use_dt   = use_dt_reg;
    assign sts.div_done = div_done;

    always_comb
    begin
        case (cmd.op)
            OP_MUL_P:
            begin
                mul_a = MA_W'(err_reg);
                mul_b = MB_W'($signed(cfg.prop_gain));
            end
            OP_MUL_D:
            begin
                mul_a = MA_W'(deriv);
                mul_b = MB_W'($signed(cfg.deriv_gain));
            end
            OP_MUL_I:
            begin
                mul_a = MA_W'(integ_reg);
                mul_b = MB_W'($signed(cfg.integ_gain));
            end
            default:
            begin
                mul_a = MA_W'(dt_reg);
                mul_b = MB_W'(err_reg);
            end
        endcase
    end

    // integral update and clamp
    always_comb
    begin
        if (use_dt_reg)
        begin
            int_add = INT_SUM_W'(prod_reg);
        end
        else
        begin
            int_add = '0;
        end
        int_sum = INT_SUM_W'(integ_reg) + int_add;
        lim_pos = INT_SUM_W'({1'b0, cfg.integ_limit});
        lim_neg = -lim_pos;
        if (int_sum > lim_pos)
        begin
            int_clamped = lim_pos;
        end
        else if (int_sum < lim_neg)
        begin
            int_clamped = lim_neg;
        end
        else
        begin
            int_clamped = int_sum;
        end
    end

    // output scaling and saturation, floor checked first
    always_comb
    begin
        shifted = acc_reg >>> (2 * FRAC_BITS);
        floor_x = ACC_W'($signed(cfg.output_floor));
        ceil_x  = ACC_W'($signed(cfg.output_ceiling));
        if (shifted < floor_x)
        begin
            sat_val = floor_x;
        end
        else if (shifted > ceil_x)
        begin
            sat_val = ceil_x;
        end
        else
        begin
            sat_val = shifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b1;
            last_err_reg  <= '0;
            last_time_reg <= '0;
            integ_reg     <= '0;
            use_dt_reg    <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LOAD:
                begin
                    use_dt_reg    <= !first_reg && (dt_in != '0);
                    first_reg     <= 1'b0;
                    last_err_reg  <= err_in;
                    last_time_reg <= time_ms;
                end
                OP_INTEG:
                begin
                    integ_reg <= int_clamped[INTEG_W-1:0];
                end
                default:
                begin
                    first_reg <= first_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                err_reg <= err_in;
                dt_reg  <= dt_in;
                num_reg <= NUM_W'(diff_in) <<< FRAC_BITS;
            end
            OP_MUL_EDT, OP_MUL_P, OP_MUL_D, OP_MUL_I:
            begin
                prod_reg <= mul_a * mul_b;
            end
            OP_ADD_P:
            begin
                acc_reg <= ACC_W'(prod_reg) <<< FRAC_BITS;
            end
            OP_ADD_D:
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
            OP_ADD_I:
            begin
                acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< FRAC_BITS);
            end
            OP_OUT:
            begin
                drive_reg <= sat_val[DRIVE_W-1:0];
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign drive = drive_reg;
    assign lim32 = {1'b0, cfg.integ_limit};

    a_integ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_INTEG) |=> (integ_reg <= lim32) && (integ_reg >= -lim32))
        else $error("integral outside clamp after update");

    a_drive_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT)
            && ($signed(cfg.output_floor) <= $signed(cfg.output_ceiling))
        |=> (drive_reg >= $signed(cfg.output_floor))
            && (drive_reg <= $signed(cfg.output_ceiling)))
        else $error("drive outside output range");

endmodule

### sv/pidc_ctrl.sv
// PID controller sequencer: input/output handshakes and datapath commands.
// Depends on pidc_pkg.
module pidc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output pidc_pkg::dp_cmd_t cmd,
    input  pidc_pkg::dp_sts_t sts
);
    import pidc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_EDT,
        S_INTEG,
        S_DIV_START,
        S_DIV_WAIT,
        S_MUL_P,
        S_ADD_P,
        S_MUL_D,
        S_ADD_D,
        S_MUL_I,
        S_ADD_I,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_MUL_EDT;
                end
            end
            S_MUL_EDT:
            begin
                cmd.op     = OP_MUL_EDT;
                state_next = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.op     = OP_INTEG;
                state_next = sts.use_dt ? S_DIV_START : S_MUL_P;
            end
            S_DIV_START:
            begin
                cmd.op     = OP_DIV_START;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    state_next = S_MUL_P;
                end
            end
            S_MUL_P:
            begin
                cmd.op     = OP_MUL_P;
                state_next = S_ADD_P;
            end
            S_ADD_P:
            begin
                cmd.op     = OP_ADD_P;
                state_next = S_MUL_D;
            end
            S_MUL_D:
            begin
                cmd.op     = OP_MUL_D;
                state_next = S_ADD_D;
            end
            S_ADD_D:
            begin
                cmd.op     = OP_ADD_D;
                state_next = S_MUL_I;
            end
            S_MUL_I:
            begin
                cmd.op     = OP_MUL_I;
                state_next = S_ADD_I;
            end
            S_ADD_I:
            begin
                cmd.op     = OP_ADD_I;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.op     = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.op == OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_stall_reg  <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_stall_reg  <= (state_next != S_IDLE);
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = in_stall_reg;
    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> !(out_valid_reg && out_stall))
        else $error("result overwritten while output stalled");

    a_div_only_with_dt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_WAIT) |-> sts.use_dt)
        else $error("divider wait without a valid time step");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> (state_reg == S_IDLE))
        else $error("transfer accepted while busy");

endmodule
